>>> hw/rtl/s256drbg_pkg.sv
package s256drbg_pkg;

	typedef struct packed {
		logic        op;
		logic [63:0] word0;
		logic [63:0] word1;
		logic [63:0] word2;
		logic [63:0] word3;
		logic [63:0] word4;
		logic [63:0] word5;
		logic [63:0] word6;
		logic [63:0] word7;
		logic        hw_valid;
	} in_req_t;

	typedef struct packed {
		logic [63:0] out_word0;
		logic [63:0] out_word1;
		logic [63:0] out_word2;
		logic [63:0] out_word3;
		logic        status;
	} out_req_t;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_GEN  = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NOT_SEEDED = 1'b1;

	typedef enum logic {
		BLK_FIRST,
		BLK_SECOND
	} blk_sel_t;

	typedef struct packed {
		logic     load;
		logic     start;
		blk_sel_t blk;
		logic     step;
		logic     finish;
		logic     commit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_round;
		logic is_seed;
		logic seeded;
	} dp_sts_t;

	localparam int NumRounds = 64;
	localparam int RoundW = $clog2(NumRounds);

	localparam logic [31:0] KRound [NumRounds] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
		32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
		32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
		32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
		32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
		32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
		32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
		32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
		32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
		32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
		32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};

	localparam logic [255:0] HInit = {
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
	};

	function automatic logic [63:0] bswap64(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = x[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/s256drbg_datapath.sv
module s256drbg_datapath
	import s256drbg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_req_t  req,
	input  dp_cmd_t  cmd,
	output dp_sts_t  sts,
	output out_req_t result
);

	logic [255:0] chain_q;
	logic [63:0]  counter_q;
	logic         seeded_q;
	in_req_t      item_q;
	logic [255:0] hmid_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [RoundW-1:0] round_q;

	logic [63:0]  cnt_next;
	logic [63:0]  ticks;
	logic [511:0] blk1, blk2, blk;
	logic [255:0] hbase;
	logic [31:0]  s0, s1, w_new, t1, t2;
	logic [255:0] hsum;

	// Message bytes are big-endian words, chain and items serialized little-endian.
	assign cnt_next = counter_q + 64'd1;
	assign ticks = item_q.hw_valid ? (item_q.word1 ^ item_q.word2) : item_q.word1;

	always_comb begin
		if (item_q.op == OP_SEED) begin
			blk1 = {chain_q, bswap64(item_q.word0), bswap64(item_q.word1),
				bswap64(item_q.word2), bswap64(item_q.word3)};
			blk2 = {bswap64(item_q.word4), bswap64(item_q.word5), bswap64(item_q.word6),
				bswap64(item_q.word7), 8'h80, 184'd0, 64'd768};
		end else begin
			blk1 = {chain_q, bswap64(counter_q), bswap64(item_q.word0),
				bswap64(ticks), 8'h80, 56'd0};
			blk2 = {448'd0, 64'd448};
		end
		blk = (cmd.blk == BLK_FIRST) ? blk1 : blk2;
		hbase = (cmd.blk == BLK_FIRST) ? HInit : hmid_q;
	end

	assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
	assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = h_q + ({e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]})
		+ ((e_q & f_q) ^ (~e_q & g_q)) + KRound[round_q] + w_q[0];
	assign t2 = ({a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]})
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	assign hsum = {hmid_q[255:224] + a_q, hmid_q[223:192] + b_q, hmid_q[191:160] + c_q,
		hmid_q[159:128] + d_q, hmid_q[127:96] + e_q, hmid_q[95:64] + f_q,
		hmid_q[63:32] + g_q, hmid_q[31:0] + h_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			counter_q <= '0;
			seeded_q <= 1'b0;
			round_q <= '0;
			item_q <= '0;
			hmid_q <= '0;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= '0;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				item_q <= req;
				if (req.op == OP_GEN && seeded_q) begin
					counter_q <= cnt_next;
				end
			end
			if (cmd.start) begin
				hmid_q <= hbase;
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= hbase;
				for (int i = 0; i < 16; i++) begin
					w_q[i] <= blk[511-32*i -: 32];
				end
				round_q <= '0;
			end else if (cmd.step) begin
				h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
				d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_new;
				round_q <= round_q + 1'b1;
			end else if (cmd.finish) begin
				hmid_q <= hsum;
			end
			if (cmd.commit) begin
				chain_q <= hmid_q;
				seeded_q <= 1'b1;
			end
		end
	end

	assign sts.last_round = (round_q == RoundW'(NumRounds - 1));
	assign sts.is_seed = (item_q.op == OP_SEED);
	assign sts.seeded = seeded_q;

	assign result.out_word0 = seeded_q ? bswap64(chain_q[255:192]) : 64'd0;
	assign result.out_word1 = seeded_q ? bswap64(chain_q[191:128]) : 64'd0;
	assign result.out_word2 = seeded_q ? bswap64(chain_q[127:64]) : 64'd0;
	assign result.out_word3 = seeded_q ? bswap64(chain_q[63:0]) : 64'd0;
	assign result.status = seeded_q ? STATUS_OK : STATUS_NOT_SEEDED;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> seeded_q)
		else $error("seeded flag not set after commit");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> round_q == '0)
		else $error("round counter not cleared at start");
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit && !cmd.load |=> $stable(chain_q) && $stable(counter_q))
		else $error("state changed without a request");

endmodule

>>> hw/rtl/s256drbg_ctrl.sv
module s256drbg_ctrl
	import s256drbg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  in_req_t req,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START1,
		ST_RUN1,
		ST_START2,
		ST_RUN2,
		ST_COMMIT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	// ST_START2 folds the first block's sum into hmid, then a start on block two follows.
	logic   start2_q;

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.blk = BLK_FIRST;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE: ;
			ST_START1: begin
				cmd.start = 1'b1;
				cmd.blk = start2_q ? BLK_SECOND : BLK_FIRST;
			end
			ST_RUN1: begin
				cmd.step = 1'b1;
				cmd.finish = 1'b0;
			end
			ST_START2: begin
				cmd.finish = 1'b1;
			end
			ST_RUN2: begin
				cmd.blk = BLK_SECOND;
				cmd.step = 1'b1;
			end
			ST_COMMIT: cmd.finish = 1'b1;
			ST_OUT: cmd.commit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			start2_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (req.op == OP_GEN && !sts.seeded) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_START1;
						end
					end
				end
				ST_START1: begin
					if (start2_q) begin
						state_q <= ST_RUN2;
					end else begin
						state_q <= ST_RUN1;
					end
				end
				ST_RUN1: if (sts.last_round) state_q <= ST_START2;
				ST_START2: begin
					start2_q <= 1'b1;
					state_q <= ST_START1;
				end
				ST_RUN2: if (sts.last_round) state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_OUT;
				ST_OUT: begin
					start2_q <= 1'b0;
					if (!sts.is_seed) out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request accepted while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_IDLE)
		else $error("commit not followed by idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN2 |-> start2_q)
		else $error("second block without first");

endmodule

>>> hw/rtl/sha256_chained_random_generator.sv
// SHA-256 hash-chain random generator.
// Input channel: in_valid/in_ready with payload in_data. op selects seed or
// generate. A seed request absorbs eight 64-bit words into the chain and
// produces no result. A generate request bumps the block counter, rehashes
// the chain with counter, timestamp and ticks, and returns the new chain.
// Output channel: out_valid/out_ready with payload out_data.
// Each request runs two SHA-256 compressions on one shared round unit, one
// round per cycle. A generate request before any seed returns status 1
// with zero data in the cycle after acceptance and leaves the chain, counter
// and seeded flag unchanged.
// One request is in flight at a time; in_ready stays low until the result is
// taken, so a stalled receiver holds the block with its state intact.
// Reset clears the chain, the counter and the seeded flag.
module sha256_chained_random_generator
	import s256drbg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	s256drbg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.req       (in_data),
		.sts       (sts),
		.cmd       (cmd)
	);

	s256drbg_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_data),
		.cmd    (cmd),
		.sts    (sts),
		.result (out_data)
	);

endmodule
